// ----- rtl/core/ipv4ph_pkg.sv -----
// Shared types and constants for the IPv4 pseudo-header checksum block.
// Used by ipv4ph_opt_walk, ipv4_pseudo_header_checksum and its bench; depends on nothing.
`timescale 1ns / 1ps

package ipv4ph_pkg;

    // IPv4 option type codes and option length limits.
    localparam logic [7:0] OPT_EOL       = 8'd0;
    localparam logic [7:0] OPT_NOP       = 8'd1;
    localparam logic [7:0] OPT_LSRR      = 8'd131;
    localparam logic [7:0] OPT_SSRR      = 8'd137;
    localparam logic [7:0] OPT_MIN_LEN   = 8'd2;
    localparam logic [7:0] ROUTE_MIN_LEN = 8'd7;

    // Header layout: minimum header length is five 32-bit words.
    localparam int unsigned MIN_IHL       = 5;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'(MIN_IHL * 4);
    localparam logic [5:0]  HDR_POS_MAX   = 6'd63;
    localparam logic [5:0]  POS_SRC_FIRST = 6'd12;
    localparam logic [5:0]  POS_DST_FIRST = 6'd16;
    localparam logic [5:0]  POS_OPT_FIRST = 6'd20;

    // Item kinds on the input channel.
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_opt_phase;

    // What the option walker reports after taking the current word.
    typedef struct packed {
        logic        found;
        logic [31:0] tail;
    } t_route_info;

endpackage

// ----- rtl/core/ipv4ph_opt_walk.sv -----
// IPv4 option list walker that finds the final hop of a source route option.
// Depends on ipv4ph_pkg for option codes, the phase enum and t_route_info.
`timescale 1ns / 1ps

module ipv4ph_opt_walk import ipv4ph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hdr_en,
    input  logic        i_clear,
    input  logic [5:0]  i_pos,
    input  logic [5:0]  i_hdr_bytes,
    input  logic [7:0]  i_byte,
    output t_route_info o_next
);

    t_opt_phase  r_phase, n_phase;
    logic [7:0]  r_rem, n_rem;
    logic        r_is_route, n_is_route;
    logic        r_stopped, n_stopped;
    logic        r_found, n_found;
    logic [31:0] r_tail, n_tail;

    logic        w_active;
    logic [6:0]  w_avail;
    logic [7:0]  w_rem_dec;
    logic [6:0]  w_pos_next;

    assign w_active   = i_hdr_en && !r_stopped && !r_found &&
                        (i_pos >= POS_OPT_FIRST) && (i_pos < i_hdr_bytes);
    assign w_avail    = {1'b0, i_hdr_bytes} - {1'b0, i_pos} + 7'd1;
    assign w_rem_dec  = r_rem - 8'd1;
    assign w_pos_next = {1'b0, i_pos} + 7'd1;

    always_comb begin
        n_phase    = r_phase;
        n_rem      = r_rem;
        n_is_route = r_is_route;
        n_stopped  = r_stopped;
        n_found    = r_found;
        n_tail     = r_tail;
        if (w_active) begin
            case (r_phase)
                PH_LEN: begin
                    if ((i_byte < OPT_MIN_LEN) || (i_byte > {1'b0, w_avail})) begin
                        n_stopped = 1'b1;
                    end else if (i_byte == OPT_MIN_LEN) begin
                        n_phase = PH_TYPE;
                    end else begin
                        n_rem      = i_byte - OPT_MIN_LEN;
                        n_is_route = r_is_route && (i_byte >= ROUTE_MIN_LEN);
                        n_phase    = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_rem = w_rem_dec;
                    if (r_is_route && (w_rem_dec < 8'd4)) begin
                        n_tail = {r_tail[23:0], i_byte};
                    end
                    if (w_rem_dec == 8'd0) begin
                        n_found = r_found || r_is_route;
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    if (i_byte == OPT_EOL) begin
                        n_stopped = 1'b1;
                    end else if (i_byte != OPT_NOP) begin
                        if (w_pos_next >= {1'b0, i_hdr_bytes}) begin
                            n_stopped = 1'b1;
                        end else begin
                            n_is_route = (i_byte == OPT_LSRR) || (i_byte == OPT_SSRR);
                            n_phase    = PH_LEN;
                        end
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end
    end

    always_comb begin
        o_next.found = n_found;
        o_next.tail  = n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase    <= PH_TYPE;
            r_rem      <= 8'd0;
            r_is_route <= 1'b0;
            r_stopped  <= 1'b0;
            r_found    <= 1'b0;
            r_tail     <= 32'd0;
        end else begin
            r_phase    <= n_phase;
            r_rem      <= n_rem;
            r_is_route <= n_is_route;
            r_stopped  <= n_stopped;
            r_found    <= n_found;
            r_tail     <= n_tail;
        end
    end

endmodule

// ----- rtl/core/ipv4_pseudo_header_checksum.sv -----
// A word marked last has its result registered in stage one, then in the output register.
// One word per cycle while o_in_ready is high; accepted words update the state.
// A result waits in the output register; input stalls only while stage one is full.
// Reset (i_rst_n low, synchronous) empties both stages and clears the packet state.
// Top level of the IPv4 pseudo-header checksum; uses ipv4ph_pkg and ipv4ph_opt_walk.
`timescale 1ns / 1ps

module ipv4_pseudo_header_checksum import ipv4ph_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic [15:0] i_segment_length,
    input  logic [7:0]  i_next_proto,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_checksum,
    output logic [31:0] o_final_destination,
    output logic        o_route_used,
    output logic        o_short_header
);

    // Handshake and pipeline control. Stage one holds the snapshot of a
    // finished packet; the output register holds the result word.
    logic w_accept;
    logic w_out_free;
    logic w_p_free;
    logic w_p_adv;
    logic r_p_valid;
    logic r_o_valid;

    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_p_adv    = r_p_valid && w_out_free;
    assign w_p_free   = !r_p_valid || w_out_free;
    assign o_in_ready = w_p_free;
    assign w_accept   = i_in_valid && w_p_free;

    // Per-packet state.
    logic [5:0]  r_hdr_pos, n_hdr_pos;
    logic [5:0]  r_hdr_bytes, n_hdr_bytes;
    logic [31:0] r_src, n_src;
    logic [31:0] r_hdr_dst, n_hdr_dst;
    logic [15:0] r_run, n_run;
    logic        r_odd, n_odd;
    logic [7:0]  r_held, n_held;

    logic        w_hdr_en;
    logic        w_clear;
    logic [16:0] w_pay_add;
    logic [16:0] w_pay_fold;
    t_route_info w_route;

    assign w_hdr_en = w_accept && (i_req_type == REQ_HEADER);
    assign w_clear  = w_accept && i_last;

    // Ones' complement add of the completed 16-bit payload word.
    assign w_pay_add  = {1'b0, r_run} + {1'b0, r_held, i_data_byte};
    assign w_pay_fold = {1'b0, w_pay_add[15:0]} + {16'd0, w_pay_add[16]};

    ipv4ph_opt_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_en    (w_hdr_en),
        .i_clear     (w_clear),
        .i_pos       (r_hdr_pos),
        .i_hdr_bytes (r_hdr_bytes),
        .i_byte      (i_data_byte),
        .o_next      (w_route)
    );

    // Header bytes capture the length and the two addresses; payload bytes
    // pair up into big-endian 16-bit words for the running sum.
    always_comb begin
        n_hdr_pos   = r_hdr_pos;
        n_hdr_bytes = r_hdr_bytes;
        n_src       = r_src;
        n_hdr_dst   = r_hdr_dst;
        n_run       = r_run;
        n_odd       = r_odd;
        n_held      = r_held;
        if (i_req_type == REQ_HEADER) begin
            if (r_hdr_pos == 6'd0) begin
                n_hdr_bytes = {i_data_byte[3:0], 2'b00};
            end else if ((r_hdr_pos >= POS_SRC_FIRST) && (r_hdr_pos < POS_DST_FIRST)) begin
                n_src = {r_src[23:0], i_data_byte};
            end else if ((r_hdr_pos >= POS_DST_FIRST) && (r_hdr_pos < POS_OPT_FIRST)) begin
                n_hdr_dst = {r_hdr_dst[23:0], i_data_byte};
            end
            if (r_hdr_pos < HDR_POS_MAX) begin
                n_hdr_pos = r_hdr_pos + 6'd1;
            end
        end else begin
            if (r_odd) begin
                n_run = w_pay_fold[15:0];
                n_odd = 1'b0;
            end else begin
                n_held = i_data_byte;
                n_odd  = 1'b1;
            end
        end
    end

    // The last word of a packet returns the state to its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_hdr_pos   <= 6'd0;
            r_hdr_bytes <= MIN_HDR_BYTES;
            r_src       <= 32'd0;
            r_hdr_dst   <= 32'd0;
            r_run       <= 16'd0;
            r_odd       <= 1'b0;
            r_held      <= 8'd0;
        end else if (w_accept) begin
            r_hdr_pos   <= n_hdr_pos;
            r_hdr_bytes <= n_hdr_bytes;
            r_src       <= n_src;
            r_hdr_dst   <= n_hdr_dst;
            r_run       <= n_run;
            r_odd       <= n_odd;
            r_held      <= n_held;
        end
    end

    // Snapshot of a finished packet, taken from the updated state so that
    // the last word itself is included.
    logic        w_short;
    logic        w_used;
    logic [31:0] w_dst;

    assign w_short = n_hdr_bytes < MIN_HDR_BYTES;
    assign w_used  = !w_short && w_route.found;
    assign w_dst   = w_used ? w_route.tail : n_hdr_dst;

    logic [31:0] r_p_src;
    logic [31:0] r_p_dst;
    logic        r_p_used;
    logic        r_p_short;
    logic [15:0] r_p_run;
    logic [15:0] r_p_pad;
    logic [7:0]  r_p_proto;
    logic [15:0] r_p_seglen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_p_free) begin
            r_p_valid <= w_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_clear) begin
            r_p_src    <= n_src;
            r_p_dst    <= w_dst;
            r_p_used   <= w_used;
            r_p_short  <= w_short;
            r_p_run    <= n_run;
            // An odd final payload byte is padded with a zero low byte.
            r_p_pad    <= n_odd ? {n_held, 8'd0} : 16'd0;
            r_p_proto  <= i_next_proto;
            r_p_seglen <= i_segment_length;
        end
    end

    // Second stage: all eight 16-bit terms are added in one wide sum and the
    // carries are folded back twice. Ones' complement addition is
    // associative, and since the sum is zero only when every term is zero,
    // this gives the same value as adding the terms one after another.
    logic [18:0] w_total;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;

    assign w_total = {3'd0, r_p_src[31:16]} + {3'd0, r_p_src[15:0]}
                   + {3'd0, r_p_dst[31:16]} + {3'd0, r_p_dst[15:0]}
                   + {11'd0, r_p_proto}     + {3'd0, r_p_seglen}
                   + {3'd0, r_p_run}        + {3'd0, r_p_pad};
    assign w_fold1 = {1'b0, w_total[15:0]} + {14'd0, w_total[18:16]};
    assign w_fold2 = {1'b0, w_fold1[15:0]} + {16'd0, w_fold1[16]};

    logic [15:0] r_o_cksum;
    logic [31:0] r_o_dst;
    logic        r_o_used;
    logic        r_o_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_adv) begin
            r_o_cksum <= ~w_fold2[15:0];
            r_o_dst   <= r_p_dst;
            r_o_used  <= r_p_used;
            r_o_short <= r_p_short;
        end
    end

    assign o_out_valid         = r_o_valid;
    assign o_checksum          = r_o_cksum;
    assign o_final_destination = r_o_dst;
    assign o_route_used        = r_o_used;
    assign o_short_header      = r_o_short;

endmodule

// ----- bench/ipv4_pseudo_header_checksum_tb.sv -----
// Self-checking bench for ipv4_pseudo_header_checksum: random packets with IPv4 options,
// a behavioral checksum predictor and a result scoreboard. Depends on ipv4ph_pkg and the RTL.
`timescale 1ns / 1ps

module ipv4_pseudo_header_checksum_tb;
    import ipv4ph_pkg::*;

    // One input word as it sits on the input channel.
    typedef struct {
        logic        req_type;
        logic [7:0]  data;
        logic        last;
        logic [15:0] seg_len;
        logic [7:0]  proto;
    } t_in_word;

    // One result word as it leaves the block.
    typedef struct {
        logic [15:0] checksum;
        logic [31:0] dst;
        logic        route_used;
        logic        short_hdr;
    } t_sum_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last = 1'b0;
    logic [15:0] i_segment_length = 16'd0;
    logic [7:0]  i_next_proto = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_checksum;
    logic [31:0] o_final_destination;
    logic        o_route_used;
    logic        o_short_header;

    ipv4_pseudo_header_checksum u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (i_req_type),
        .i_data_byte         (i_data_byte),
        .i_last              (i_last),
        .i_segment_length    (i_segment_length),
        .i_next_proto        (i_next_proto),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_checksum          (o_checksum),
        .o_final_destination (o_final_destination),
        .o_route_used        (o_route_used),
        .o_short_header      (o_short_header)
    );

    t_in_word    words_to_send[$];
    t_sum_result checksums_due[$];
    int          word_total = 0;
    int          packets_built = 0;
    int          fail_count = 0;

    // Packet state of the predictor.
    logic [5:0]  hdr_pos;
    logic [5:0]  hdr_len;
    logic [31:0] src_addr;
    logic [31:0] hdr_dst;
    t_opt_phase  opt_phase;
    logic [7:0]  opt_left;
    logic        opt_route;
    logic        walk_done;
    logic        route_seen;
    logic [31:0] route_addr;
    logic [31:0] pay_sum;
    logic        pay_odd;
    logic [7:0]  pay_hi;

    // Driver and monitor bookkeeping.
    t_in_word    cur_word;
    t_sum_result exp_sum;
    int          sent_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        idle_allowed = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [31:0] fold16(input logic [31:0] acc, input logic [15:0] w);
        logic [31:0] s;
        s = acc + {16'd0, w};
        return {16'd0, s[15:0]} + {16'd0, s[31:16]};
    endfunction

    task automatic clear_packet_state();
        hdr_pos    = '0;
        hdr_len    = MIN_HDR_BYTES;
        src_addr   = '0;
        hdr_dst    = '0;
        opt_phase  = PH_TYPE;
        opt_left   = '0;
        opt_route  = 1'b0;
        walk_done  = 1'b0;
        route_seen = 1'b0;
        route_addr = '0;
        pay_sum    = '0;
        pay_odd    = 1'b0;
        pay_hi     = '0;
    endtask

    // Advances the option walk by one header byte at position p.
    task automatic walk_option_byte(input int p, input logic [7:0] b);
        int room;
        if (walk_done || route_seen || p < int'(POS_OPT_FIRST) || p >= int'(hdr_len))
            return;
        case (opt_phase)
            PH_LEN: begin
                // The option started one byte back, so it may span up to the header end.
                room = int'(hdr_len) - p + 1;
                if (b < OPT_MIN_LEN || int'(b) > room) begin
                    walk_done = 1'b1;
                end else if (b == OPT_MIN_LEN) begin
                    opt_phase = PH_TYPE;
                end else begin
                    opt_left  = b - OPT_MIN_LEN;
                    opt_route = opt_route && (b >= ROUTE_MIN_LEN);
                    opt_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                opt_left = opt_left - 8'd1;
                // The last four body bytes of a route option are the final hop.
                if (opt_route && opt_left < 8'd4)
                    route_addr = {route_addr[23:0], b};
                if (opt_left == 8'd0) begin
                    if (opt_route)
                        route_seen = 1'b1;
                    opt_phase = PH_TYPE;
                end
            end
            default: begin
                if (b == OPT_EOL) begin
                    walk_done = 1'b1;
                end else if (b != OPT_NOP) begin
                    if (p + 1 >= int'(hdr_len)) begin
                        walk_done = 1'b1;
                    end else begin
                        opt_route = (b == OPT_LSRR) || (b == OPT_SSRR);
                        opt_phase = PH_LEN;
                    end
                end
            end
        endcase
    endtask

    // Applies one accepted word to the predictor; a last word yields the expected result.
    task automatic track_packet_word(input t_in_word w);
        logic [31:0] s;
        logic [31:0] dst;
        logic        short_hdr;
        logic        via_route;
        t_sum_result r;
        if (w.req_type == REQ_HEADER) begin
            if (hdr_pos == 6'd0)
                hdr_len = {w.data[3:0], 2'b00};
            else if (hdr_pos >= POS_SRC_FIRST && hdr_pos < POS_DST_FIRST)
                src_addr = {src_addr[23:0], w.data};
            else if (hdr_pos >= POS_DST_FIRST && hdr_pos < POS_OPT_FIRST)
                hdr_dst = {hdr_dst[23:0], w.data};
            walk_option_byte(int'(hdr_pos), w.data);
            if (hdr_pos < HDR_POS_MAX)
                hdr_pos = hdr_pos + 6'd1;
        end else if (pay_odd) begin
            pay_sum = fold16(pay_sum, {pay_hi, w.data});
            pay_odd = 1'b0;
        end else begin
            pay_hi  = w.data;
            pay_odd = 1'b1;
        end
        if (w.last) begin
            short_hdr = hdr_len < MIN_HDR_BYTES;
            via_route = !short_hdr && route_seen;
            dst = via_route ? route_addr : hdr_dst;
            s = pay_sum;
            // An odd trailing payload byte is padded with a zero low byte.
            if (pay_odd)
                s = fold16(s, {pay_hi, 8'h00});
            s = fold16(s, src_addr[31:16]);
            s = fold16(s, src_addr[15:0]);
            s = fold16(s, dst[31:16]);
            s = fold16(s, dst[15:0]);
            s = fold16(s, {8'h00, w.proto});
            s = fold16(s, w.seg_len);
            r.checksum   = ~s[15:0];
            r.dst        = dst;
            r.route_used = via_route;
            r.short_hdr  = short_hdr;
            checksums_due.push_back(r);
            clear_packet_state();
        end
    endtask

    function automatic logic [15:0] pick_seg();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_word(input logic req, input logic [7:0] data, input logic last,
                            input logic [15:0] seg, input logic [7:0] proto);
        t_in_word w;
        w.req_type = req;
        w.data     = data;
        w.last     = last;
        w.seg_len  = seg;
        w.proto    = proto;
        words_to_send.push_back(w);
        word_total++;
    endtask

    // Builds one packet. Kinds 0-6 are well formed, 7 has a short header length,
    // 8 is a damaged packet and 9 is a run of random words.
    task automatic queue_packet(input int kind);
        logic [7:0] hdr[$];
        logic [7:0] pay[$];
        logic       wreq[$];
        logic [7:0] wdat[$];
        int         ihl;
        int         hlen;
        int         room;
        int         olen;
        int         n;
        int         mid;
        int         damage;
        logic [7:0] otype;
        logic       stray_hdr;
        logic       no_payload;
        logic       all_ones;
        stray_hdr  = 1'b0;
        no_payload = 1'b0;
        damage     = -1;
        packets_built++;
        if (kind == 9) begin
            n = $urandom_range(1, 30);
            repeat (n) begin
                wreq.push_back(1'($urandom_range(0, 1)));
                wdat.push_back(8'($urandom));
            end
        end else begin
            ihl  = (kind == 7) ? $urandom_range(0, 4) : $urandom_range(5, 15);
            hlen = ihl * 4;
            hdr.push_back({4'($urandom_range(0, 15)), 4'(ihl)});
            if (kind == 7) begin
                n = $urandom_range(1, 24);
                while (hdr.size() < n)
                    hdr.push_back(8'($urandom));
            end else begin
                while (hdr.size() < 20)
                    hdr.push_back(8'($urandom));
                // Option list, well formed up to the header end.
                while (hdr.size() < hlen) begin
                    room = hlen - hdr.size();
                    case ($urandom_range(0, 7))
                        0, 1: hdr.push_back(OPT_NOP);
                        2: begin
                            hdr.push_back(OPT_EOL);
                            while (hdr.size() < hlen)
                                hdr.push_back(8'($urandom));
                        end
                        3, 4, 5: begin
                            if (room < 3) begin
                                hdr.push_back(OPT_NOP);
                            end else begin
                                otype = $urandom_range(0, 1) ? OPT_LSRR : OPT_SSRR;
                                if (room >= 7 && $urandom_range(0, 3) != 0)
                                    olen = $urandom_range(7, room);
                                else
                                    olen = $urandom_range(2, (room < 6) ? room : 6);
                                hdr.push_back(otype);
                                hdr.push_back(8'(olen));
                                repeat (olen - 2) hdr.push_back(8'($urandom));
                            end
                        end
                        default: begin
                            if (room < 2) begin
                                hdr.push_back(OPT_NOP);
                            end else begin
                                olen = $urandom_range(2, room);
                                hdr.push_back(8'($urandom_range(2, 255)));
                                hdr.push_back(8'(olen));
                                repeat (olen - 2) hdr.push_back(8'($urandom));
                            end
                        end
                    endcase
                end
            end
            if (kind == 8)
                damage = $urandom_range(0, 4);
            case (damage)
                0: begin
                    // Corrupt one option byte, often into a tiny length or type.
                    if (hlen > 20)
                        hdr[$urandom_range(20, hlen - 1)] =
                            $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
                end
                1: begin
                    // Header cut short; with no payload, last lands on a header byte.
                    n = $urandom_range(1, hdr.size());
                    while (hdr.size() > n)
                        void'(hdr.pop_back());
                    no_payload = 1'($urandom_range(0, 1));
                end
                2: begin
                    // Header bytes past the stated length, sometimes past position 63.
                    n = $urandom_range(hlen, 70);
                    while (hdr.size() < n)
                        hdr.push_back(8'($urandom));
                end
                3: stray_hdr = 1'b1;
                4: hdr.delete();
                default: ;
            endcase
            if (!no_payload) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
                all_ones = ($urandom_range(0, 9) == 0);
                repeat (n) pay.push_back(all_ones ? 8'hFF : 8'($urandom));
            end
            foreach (hdr[i]) begin
                wreq.push_back(REQ_HEADER);
                wdat.push_back(hdr[i]);
            end
            mid = (pay.size() > 0) ? $urandom_range(0, pay.size() - 1) : 0;
            foreach (pay[i]) begin
                if (stray_hdr && i == mid) begin
                    wreq.push_back(REQ_HEADER);
                    wdat.push_back(8'($urandom));
                end
                wreq.push_back(REQ_PAYLOAD);
                wdat.push_back(pay[i]);
            end
            if (wdat.size() == 0) begin
                wreq.push_back(REQ_PAYLOAD);
                wdat.push_back(8'($urandom));
            end
        end
        for (int i = 0; i < wdat.size(); i++)
            add_word(wreq[i], wdat[i], i == wdat.size() - 1, pick_seg(), pick_proto());
    endtask

    // Driver: holds a word until it is taken, then either idles for a burst or
    // presents the next pending word. The predictor sees each word as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid   <= 1'b0;
            idle_allowed <= 1'b0;
            gap_left     <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                track_packet_word(cur_word);
            // Idling runs in stretches and stops for the final part of the run.
            idle_allowed <= (words_to_send.size() > 150) && (((sent_count / 200) % 3) != 2);
            if (i_in_valid && !o_in_ready) begin
                // Hold the word and its payload until accepted.
            end else if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
                gap_left   <= $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                cur_word = words_to_send.pop_front();
                sent_count++;
                i_req_type       <= cur_word.req_type;
                i_data_byte      <= cur_word.data;
                i_last           <= cur_word.last;
                i_segment_length <= cur_word.seg_len;
                i_next_proto     <= cur_word.proto;
                i_in_valid       <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result with the oldest prediction and
    // stalls the result channel in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (checksums_due.size() == 0) begin
                    $display("%0t: unexpected result, checksum %h destination %h",
                             $time, o_checksum, o_final_destination);
                    fail_count++;
                end else begin
                    exp_sum = checksums_due.pop_front();
                    if (o_checksum !== exp_sum.checksum) begin
                        $display("%0t: checksum expected %h actual %h",
                                 $time, exp_sum.checksum, o_checksum);
                        fail_count++;
                    end
                    if (o_final_destination !== exp_sum.dst) begin
                        $display("%0t: final_destination expected %h actual %h",
                                 $time, exp_sum.dst, o_final_destination);
                        fail_count++;
                    end
                    if (o_route_used !== exp_sum.route_used) begin
                        $display("%0t: route_used expected %b actual %b",
                                 $time, exp_sum.route_used, o_route_used);
                        fail_count++;
                    end
                    if (o_short_header !== exp_sum.short_hdr) begin
                        $display("%0t: short_header expected %b actual %b",
                                 $time, exp_sum.short_hdr, o_short_header);
                        fail_count++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
                stall_left  <= $urandom_range(0, 13);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int kind;
        clear_packet_state();
        // Directed part: a header length of zero with last on the first byte,
        // all-ones payload with extreme length and protocol, a single odd payload
        // byte, a header cut after two bytes, and a header byte inside the payload.
        add_word(REQ_HEADER, 8'h40, 1'b1, 16'hFFFF, 8'hFF);
        add_word(REQ_PAYLOAD, 8'hFF, 1'b0, 16'h0000, 8'h00);
        add_word(REQ_PAYLOAD, 8'hFF, 1'b1, 16'h0000, 8'h00);
        add_word(REQ_PAYLOAD, 8'h80, 1'b1, 16'hFFFF, 8'h11);
        add_word(REQ_HEADER, 8'h4F, 1'b0, 16'h1234, 8'h06);
        add_word(REQ_HEADER, 8'h00, 1'b1, 16'hFFFF, 8'hFF);
        add_word(REQ_PAYLOAD, 8'h12, 1'b0, 16'h0000, 8'h00);
        add_word(REQ_HEADER, 8'h45, 1'b0, 16'h0000, 8'h00);
        add_word(REQ_PAYLOAD, 8'h34, 1'b1, 16'h0008, 8'h11);
        // Random part, mostly well-formed packets.
        while (word_total < 1650 || packets_built < 48) begin
            kind = $urandom_range(0, 9);
            queue_packet(kind);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (checksums_due.size() != 0)
            @(posedge i_clk);
        // Allow a margin after the last word for stray results.
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ipv4ph_pkg.sv
rtl/core/ipv4ph_opt_walk.sv
rtl/core/ipv4_pseudo_header_checksum.sv
bench/ipv4_pseudo_header_checksum_tb.sv
